>>> rtl/trg_pkg.sv
// Package for the triage store engine: record layout, operation, store,
// status and placement codes, sequencer state and default store depths.
// No dependencies.
`default_nettype none

package trg_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int FIFO_DEPTH_DEF  = 16;
    localparam int RING_DEPTH_DEF  = 8;

    localparam int ID_W    = 16;
    localparam int AGE_W   = 8;
    localparam int SEV_W   = 3;
    localparam int REC_W   = ID_W + AGE_W + SEV_W;
    localparam int MODE_W  = 3;
    localparam int SEL_W   = 2;
    localparam int STAT_W  = 3;
    localparam int PLACE_W = 2;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [AGE_W-1:0] age;
        logic [SEV_W-1:0] sev;
    } rec_t;

    localparam logic [MODE_W-1:0] MODE_ADMIT     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP_STACK = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FIFO  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_RING  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_XFER      = 3'd4;

    localparam logic [SEL_W-1:0] SEL_NONE  = 2'd0;
    localparam logic [SEL_W-1:0] SEL_STACK = 2'd1;
    localparam logic [SEL_W-1:0] SEL_FIFO  = 2'd2;
    localparam logic [SEL_W-1:0] SEL_RING  = 2'd3;

    localparam logic [STAT_W-1:0] STATUS_OK          = 3'd0;
    localparam logic [STAT_W-1:0] STATUS_EMPTY       = 3'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL        = 3'd2;
    localparam logic [STAT_W-1:0] STATUS_INVALID_DST = 3'd3;
    localparam logic [STAT_W-1:0] STATUS_INVALID_SRC = 3'd4;

    localparam logic [PLACE_W-1:0] PLACED_STACK = 2'd0;
    localparam logic [PLACE_W-1:0] PLACED_FIFO  = 2'd1;
    localparam logic [PLACE_W-1:0] PLACED_RING  = 2'd2;
    localparam logic [PLACE_W-1:0] PLACED_NONE  = 2'd3;

    localparam logic [SEV_W-1:0] THRESH_RESET = 3'd4;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic accept;
        logic fire;
    } seq_ctl_t;

endpackage

`default_nettype wire

>>> rtl/trg_ram.sv
// Generic synchronous RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module trg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/trg_seq.sv
// Sequencer: accept/execute state machine and output valid register.
// Depends on trg_pkg.
`default_nettype none

module trg_seq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output trg_pkg::seq_ctl_t     ctl
);

    trg_pkg::state_t state_reg;
    trg_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            trg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = trg_pkg::ST_EXEC;
                end
            end
            trg_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = trg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = trg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        ctl.accept = 1'b0;
        ctl.fire   = 1'b0;
        unique case (state_reg)
            trg_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                ctl.accept = in_valid;
            end
            trg_pkg::ST_EXEC:
            begin
                ctl.fire = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= trg_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> rtl/trg_core.sv
// Store pointers and counts, pop/push decisions, memory addressing and
// result registers. Depends on trg_pkg; drives the shared record RAM.
`default_nettype none

module trg_core #(
    parameter int STACK_DEPTH = trg_pkg::STACK_DEPTH_DEF,
    parameter int FIFO_DEPTH  = trg_pkg::FIFO_DEPTH_DEF,
    parameter int RING_DEPTH  = trg_pkg::RING_DEPTH_DEF,
    localparam int TOTAL      = STACK_DEPTH + FIFO_DEPTH + RING_DEPTH,
    localparam int AW         = $clog2(TOTAL),
    localparam int SCW        = $clog2(STACK_DEPTH + 1),
    localparam int FCW        = $clog2(FIFO_DEPTH + 1),
    localparam int RCW        = $clog2(RING_DEPTH + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire trg_pkg::seq_ctl_t             ctl,
    input  wire logic                          cfg_wr_en,
    input  wire logic [trg_pkg::SEV_W-1:0]     cfg_wr_data,
    input  wire logic [trg_pkg::MODE_W-1:0]    mode,
    input  wire logic [trg_pkg::ID_W-1:0]      record_id,
    input  wire logic [trg_pkg::AGE_W-1:0]     record_age,
    input  wire logic [trg_pkg::SEV_W-1:0]     record_severity,
    input  wire logic [1:0]                    sector_choice,
    input  wire logic [trg_pkg::SEL_W-1:0]     source_store,
    input  wire logic [trg_pkg::SEL_W-1:0]     dest_store,
    output logic                               ram_rd_en,
    output logic      [AW-1:0]                 ram_rd_addr,
    input  wire logic [trg_pkg::REC_W-1:0]     ram_rd_data,
    output logic                               ram_wr_en,
    output logic      [AW-1:0]                 ram_wr_addr,
    output logic      [trg_pkg::REC_W-1:0]     ram_wr_data,
    output logic      [trg_pkg::STAT_W-1:0]    status,
    output logic                               served_valid,
    output logic      [trg_pkg::ID_W-1:0]      served_id,
    output logic      [trg_pkg::AGE_W-1:0]     served_age,
    output logic      [trg_pkg::SEV_W-1:0]     served_severity,
    output logic      [trg_pkg::PLACE_W-1:0]   placed_store,
    output logic                               evicted_oldest,
    output logic      [SCW-1:0]                stack_count,
    output logic      [FCW-1:0]                fifo_count,
    output logic      [RCW-1:0]                ring_count
);

    localparam int SW        = $clog2(STACK_DEPTH);
    localparam int FW        = $clog2(FIFO_DEPTH);
    localparam int RW        = $clog2(RING_DEPTH);
    localparam int FIFO_BASE = STACK_DEPTH;
    localparam int RING_BASE = STACK_DEPTH + FIFO_DEPTH;

    // configuration and pointer state
    logic [trg_pkg::SEV_W-1:0] thresh_reg;
    logic [SCW-1:0]            stack_fill_reg;
    logic [SCW-1:0]            stack_fill_next;
    logic [FW-1:0]             fifo_head_reg;
    logic [FW-1:0]             fifo_head_next;
    logic [FCW-1:0]            fifo_fill_reg;
    logic [FCW-1:0]            fifo_fill_next;
    logic [RW-1:0]             ring_head_reg;
    logic [RW-1:0]             ring_head_next;
    logic [RCW-1:0]            ring_fill_reg;
    logic [RCW-1:0]            ring_fill_next;

    // latched transaction
    logic [trg_pkg::MODE_W-1:0] mode_reg;
    trg_pkg::rec_t              rec_reg;
    logic [1:0]                 sector_reg;
    logic [trg_pkg::SEL_W-1:0]  src_reg;
    logic [trg_pkg::SEL_W-1:0]  dst_reg;

    // result registers
    logic [trg_pkg::STAT_W-1:0]  status_reg;
    logic [trg_pkg::STAT_W-1:0]  status_next;
    logic                        served_valid_reg;
    logic                        served_valid_next;
    trg_pkg::rec_t               served_rec_reg;
    trg_pkg::rec_t               served_rec_next;
    logic [trg_pkg::PLACE_W-1:0] placed_reg;
    logic [trg_pkg::PLACE_W-1:0] placed_next;
    logic                        evicted_reg;
    logic                        evicted_next;

    // working values
    logic [SCW-1:0]            stack_top;
    logic [trg_pkg::SEL_W-1:0] rd_sel;
    logic [trg_pkg::SEL_W-1:0] pop_sel;
    logic                      pop_ok;
    logic [SCW-1:0]            s_fill1;
    logic [FW-1:0]             f_head1;
    logic [FCW-1:0]            f_fill1;
    logic [RW-1:0]             r_head1;
    logic [RCW-1:0]            r_fill1;
    logic [FW:0]               f_sum;
    logic [FW-1:0]             f_wr_idx;
    logic [RW:0]               r_sum;
    logic [RW-1:0]             r_wr_idx;
    logic                      push_try;
    logic [trg_pkg::SEL_W-1:0] push_sel;
    trg_pkg::rec_t             push_rec;

    assign stack_top = stack_fill_reg - SCW'(1);

    // read issue in the accept cycle
    always_comb
    begin
        rd_sel = trg_pkg::SEL_NONE;
        unique case (mode) inside
            trg_pkg::MODE_POP_STACK, trg_pkg::MODE_POP_FIFO, trg_pkg::MODE_POP_RING:
            begin
                rd_sel = mode[trg_pkg::SEL_W-1:0];
            end
            trg_pkg::MODE_XFER:
            begin
                rd_sel = source_store;
            end
            default:
            begin
                rd_sel = trg_pkg::SEL_NONE;
            end
        endcase
    end

    always_comb
    begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = AW'(stack_top[SW-1:0]);
        unique case (rd_sel)
            trg_pkg::SEL_STACK:
            begin
                ram_rd_en   = ctl.accept && (stack_fill_reg != '0);
                ram_rd_addr = AW'(stack_top[SW-1:0]);
            end
            trg_pkg::SEL_FIFO:
            begin
                ram_rd_en   = ctl.accept && (fifo_fill_reg != '0);
                ram_rd_addr = AW'(FIFO_BASE) + AW'(fifo_head_reg);
            end
            trg_pkg::SEL_RING:
            begin
                ram_rd_en   = ctl.accept && (ring_fill_reg != '0);
                ram_rd_addr = AW'(RING_BASE) + AW'(ring_head_reg);
            end
            default:
            begin
                ram_rd_en = 1'b0;
            end
        endcase
    end

    // pop stage of the execute cycle
    always_comb
    begin
        pop_sel = trg_pkg::SEL_NONE;
        unique case (mode_reg) inside
            trg_pkg::MODE_POP_STACK, trg_pkg::MODE_POP_FIFO, trg_pkg::MODE_POP_RING:
            begin
                pop_sel = mode_reg[trg_pkg::SEL_W-1:0];
            end
            trg_pkg::MODE_XFER:
            begin
                pop_sel = src_reg;
            end
            default:
            begin
                pop_sel = trg_pkg::SEL_NONE;
            end
        endcase
    end

    always_comb
    begin
        pop_ok  = 1'b0;
        s_fill1 = stack_fill_reg;
        f_head1 = fifo_head_reg;
        f_fill1 = fifo_fill_reg;
        r_head1 = ring_head_reg;
        r_fill1 = ring_fill_reg;
        case (pop_sel)
            trg_pkg::SEL_STACK:
            begin
                if (stack_fill_reg != '0)
                begin
                    pop_ok  = 1'b1;
                    s_fill1 = stack_top;
                end
            end
            trg_pkg::SEL_FIFO:
            begin
                if (fifo_fill_reg != '0)
                begin
                    pop_ok  = 1'b1;
                    f_fill1 = fifo_fill_reg - FCW'(1);
                    f_head1 = (fifo_head_reg == FW'(FIFO_DEPTH - 1)) ? '0
                                                                  : fifo_head_reg + FW'(1);
                end
            end
            trg_pkg::SEL_RING:
            begin
                if (ring_fill_reg != '0)
                begin
                    pop_ok  = 1'b1;
                    r_fill1 = ring_fill_reg - RCW'(1);
                    r_head1 = (ring_head_reg == RW'(RING_DEPTH - 1)) ? '0
                                                                  : ring_head_reg + RW'(1);
                end
            end
            default:
            begin
                pop_ok = 1'b0;
            end
        endcase
    end

    // push target and record
    always_comb
    begin
        push_try = 1'b0;
        push_sel = trg_pkg::SEL_NONE;
        push_rec = rec_reg;
        if (mode_reg == trg_pkg::MODE_ADMIT)
        begin
            push_try = 1'b1;
            if (rec_reg.sev >= thresh_reg)
            begin
                push_sel = trg_pkg::SEL_STACK;
            end
            else if (sector_reg == 2'(trg_pkg::SEL_FIFO))
            begin
                push_sel = trg_pkg::SEL_FIFO;
            end
            else
            begin
                push_sel = trg_pkg::SEL_RING;
            end
        end
        else if (mode_reg == trg_pkg::MODE_XFER && pop_ok)
        begin
            push_try = 1'b1;
            push_sel = dst_reg;
            push_rec = trg_pkg::rec_t'(ram_rd_data);
        end
    end

    assign f_sum    = {1'b0, f_head1} + (FW + 1)'(f_fill1);
    assign f_wr_idx = (f_sum >= (FW + 1)'(FIFO_DEPTH)) ? FW'(f_sum - (FW + 1)'(FIFO_DEPTH))
                                                        : FW'(f_sum);
    assign r_sum    = {1'b0, r_head1} + (RW + 1)'(r_fill1);
    assign r_wr_idx = (r_sum >= (RW + 1)'(RING_DEPTH)) ? RW'(r_sum - (RW + 1)'(RING_DEPTH))
                                                        : RW'(r_sum);

    // push stage, status and next pointers
    always_comb
    begin
        stack_fill_next   = s_fill1;
        fifo_head_next    = f_head1;
        fifo_fill_next    = f_fill1;
        ring_head_next    = r_head1;
        ring_fill_next    = r_fill1;
        ram_wr_en         = 1'b0;
        ram_wr_addr       = AW'(s_fill1[SW-1:0]);
        ram_wr_data       = push_rec;
        status_next       = trg_pkg::STATUS_OK;
        placed_next       = trg_pkg::PLACED_NONE;
        evicted_next      = 1'b0;
        served_valid_next = 1'b0;
        served_rec_next   = '0;

        unique case (mode_reg) inside
            trg_pkg::MODE_POP_STACK, trg_pkg::MODE_POP_FIFO, trg_pkg::MODE_POP_RING:
            begin
                if (pop_ok)
                begin
                    served_valid_next = 1'b1;
                    served_rec_next   = trg_pkg::rec_t'(ram_rd_data);
                end
                else
                begin
                    status_next = trg_pkg::STATUS_EMPTY;
                end
            end
            trg_pkg::MODE_XFER:
            begin
                if (src_reg == trg_pkg::SEL_NONE)
                begin
                    status_next = trg_pkg::STATUS_INVALID_SRC;
                end
                else if (!pop_ok)
                begin
                    status_next = trg_pkg::STATUS_EMPTY;
                end
            end
            default:
            begin
                status_next = trg_pkg::STATUS_OK;
            end
        endcase

        if (push_try)
        begin
            case (push_sel)
                trg_pkg::SEL_STACK:
                begin
                    if (s_fill1 == SCW'(STACK_DEPTH))
                    begin
                        status_next = trg_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        ram_wr_en       = ctl.fire;
                        ram_wr_addr     = AW'(s_fill1[SW-1:0]);
                        stack_fill_next = s_fill1 + SCW'(1);
                        placed_next     = trg_pkg::PLACED_STACK;
                    end
                end
                trg_pkg::SEL_FIFO:
                begin
                    if (f_fill1 == FCW'(FIFO_DEPTH))
                    begin
                        status_next = trg_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        ram_wr_en      = ctl.fire;
                        ram_wr_addr    = AW'(FIFO_BASE) + AW'(f_wr_idx);
                        fifo_fill_next = f_fill1 + FCW'(1);
                        placed_next    = trg_pkg::PLACED_FIFO;
                    end
                end
                trg_pkg::SEL_RING:
                begin
                    ram_wr_en   = ctl.fire;
                    ram_wr_addr = AW'(RING_BASE) + AW'(r_wr_idx);
                    placed_next = trg_pkg::PLACED_RING;
                    if (r_fill1 == RCW'(RING_DEPTH))
                    begin
                        evicted_next   = 1'b1;
                        ring_head_next = (r_head1 == RW'(RING_DEPTH - 1)) ? '0
                                                                        : r_head1 + RW'(1);
                    end
                    else
                    begin
                        ring_fill_next = r_fill1 + RCW'(1);
                    end
                end
                default:
                begin
                    status_next = trg_pkg::STATUS_INVALID_DST;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg     <= trg_pkg::THRESH_RESET;
            stack_fill_reg <= '0;
            fifo_head_reg  <= '0;
            fifo_fill_reg  <= '0;
            ring_head_reg  <= '0;
            ring_fill_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                thresh_reg <= cfg_wr_data;
            end
            if (ctl.fire)
            begin
                stack_fill_reg <= stack_fill_next;
                fifo_head_reg  <= fifo_head_next;
                fifo_fill_reg  <= fifo_fill_next;
                ring_head_reg  <= ring_head_next;
                ring_fill_reg  <= ring_fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            mode_reg   <= mode;
            rec_reg    <= '{id: record_id, age: record_age, sev: record_severity};
            sector_reg <= sector_choice;
            src_reg    <= source_store;
            dst_reg    <= dest_store;
        end
        if (ctl.fire)
        begin
            status_reg       <= status_next;
            served_valid_reg <= served_valid_next;
            served_rec_reg   <= served_rec_next;
            placed_reg       <= placed_next;
            evicted_reg      <= evicted_next;
        end
    end

    assign status          = status_reg;
    assign served_valid    = served_valid_reg;
    assign served_id       = served_rec_reg.id;
    assign served_age      = served_rec_reg.age;
    assign served_severity = served_rec_reg.sev;
    assign placed_store    = placed_reg;
    assign evicted_oldest  = evicted_reg;
    assign stack_count     = stack_fill_reg;
    assign fifo_count      = fifo_fill_reg;
    assign ring_count      = ring_fill_reg;

endmodule

`default_nettype wire

>>> rtl/triage_stack_fifo_ring_engine_top.sv
// Top level of the triage store engine: stack, FIFO and overwriting ring
// sharing one record RAM. Depends on trg_pkg, trg_ram, trg_seq, trg_core.
//
//   channel | handshake             | payload
//   --------+-----------------------+---------------------------------------
//   in      | in_valid / in_ready   | mode, record_*, sector_choice, *_store
//   out     | out_valid / out_ready | status, served_*, placed_store,
//           |                       | evicted_oldest, *_count
//   cfg     | cfg_wr_en             | cfg_wr_data (severity threshold)
//
// Each transaction passes through an accept cycle, which issues the RAM read,
// and an execute cycle, which writes back, updates the pointers and loads the
// result register, as the shared record RAM has a registered read.
// Reset clears pointers and counts at once; RAM contents stay undefined.
// A waiting result does not block the next accept; the execute cycle holds
// until the result register is free.
`default_nettype none

module triage_stack_fifo_ring_engine_top #(
    parameter int STACK_DEPTH = trg_pkg::STACK_DEPTH_DEF,
    parameter int FIFO_DEPTH  = trg_pkg::FIFO_DEPTH_DEF,
    parameter int RING_DEPTH  = trg_pkg::RING_DEPTH_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [trg_pkg::SEV_W-1:0]             cfg_wr_data,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [trg_pkg::MODE_W-1:0]            mode,
    input  wire logic [trg_pkg::ID_W-1:0]              record_id,
    input  wire logic [trg_pkg::AGE_W-1:0]             record_age,
    input  wire logic [trg_pkg::SEV_W-1:0]             record_severity,
    input  wire logic [1:0]                            sector_choice,
    input  wire logic [trg_pkg::SEL_W-1:0]             source_store,
    input  wire logic [trg_pkg::SEL_W-1:0]             dest_store,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic      [trg_pkg::STAT_W-1:0]            status,
    output logic                                       served_valid,
    output logic      [trg_pkg::ID_W-1:0]              served_id,
    output logic      [trg_pkg::AGE_W-1:0]             served_age,
    output logic      [trg_pkg::SEV_W-1:0]             served_severity,
    output logic      [trg_pkg::PLACE_W-1:0]           placed_store,
    output logic                                       evicted_oldest,
    output logic      [$clog2(STACK_DEPTH + 1)-1:0]    stack_count,
    output logic      [$clog2(FIFO_DEPTH + 1)-1:0]     fifo_count,
    output logic      [$clog2(RING_DEPTH + 1)-1:0]     ring_count
);

    localparam int TOTAL = STACK_DEPTH + FIFO_DEPTH + RING_DEPTH;
    localparam int AW    = $clog2(TOTAL);

    trg_pkg::seq_ctl_t          ctl;
    logic                       ram_rd_en;
    logic [AW-1:0]              ram_rd_addr;
    logic [trg_pkg::REC_W-1:0]  ram_rd_data;
    logic                       ram_wr_en;
    logic [AW-1:0]              ram_wr_addr;
    logic [trg_pkg::REC_W-1:0]  ram_wr_data;

    trg_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl)
    );

    trg_core #(
        .STACK_DEPTH (STACK_DEPTH),
        .FIFO_DEPTH  (FIFO_DEPTH),
        .RING_DEPTH  (RING_DEPTH)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .mode            (mode),
        .record_id       (record_id),
        .record_age      (record_age),
        .record_severity (record_severity),
        .sector_choice   (sector_choice),
        .source_store    (source_store),
        .dest_store      (dest_store),
        .ram_rd_en       (ram_rd_en),
        .ram_rd_addr     (ram_rd_addr),
        .ram_rd_data     (ram_rd_data),
        .ram_wr_en       (ram_wr_en),
        .ram_wr_addr     (ram_wr_addr),
        .ram_wr_data     (ram_wr_data),
        .status          (status),
        .served_valid    (served_valid),
        .served_id       (served_id),
        .served_age      (served_age),
        .served_severity (served_severity),
        .placed_store    (placed_store),
        .evicted_oldest  (evicted_oldest),
        .stack_count     (stack_count),
        .fifo_count      (fifo_count),
        .ring_count      (ring_count)
    );

    trg_ram #(
        .WIDTH (trg_pkg::REC_W),
        .DEPTH (TOTAL)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire

>>> rtl/trg_checker.sv
// Port-level checker for the triage store engine, bound to the top level.
// Depends on trg_pkg and triage_stack_fifo_ring_engine_top.
`default_nettype none

module trg_checker #(
    parameter int STACK_DEPTH = trg_pkg::STACK_DEPTH_DEF,
    parameter int FIFO_DEPTH  = trg_pkg::FIFO_DEPTH_DEF,
    parameter int RING_DEPTH  = trg_pkg::RING_DEPTH_DEF
) (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               in_valid,
    input wire logic                               in_ready,
    input wire logic                               out_valid,
    input wire logic [trg_pkg::STAT_W-1:0]         status,
    input wire logic                               served_valid,
    input wire logic [trg_pkg::ID_W-1:0]           served_id,
    input wire logic [trg_pkg::AGE_W-1:0]          served_age,
    input wire logic [trg_pkg::SEV_W-1:0]          served_severity,
    input wire logic [trg_pkg::PLACE_W-1:0]        placed_store,
    input wire logic                               evicted_oldest,
    input wire logic [$clog2(STACK_DEPTH + 1)-1:0] stack_count,
    input wire logic [$clog2(FIFO_DEPTH + 1)-1:0]  fifo_count,
    input wire logic [$clog2(RING_DEPTH + 1)-1:0]  ring_count
);

    // one transaction in flight at a time
    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready held high after accept");

    a_served_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && served_valid |->
            status == trg_pkg::STATUS_OK && placed_store == trg_pkg::PLACED_NONE)
        else $error("served record with bad status or placement");

    a_unserved_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !served_valid |->
            served_id == '0 && served_age == '0 && served_severity == '0)
        else $error("served fields not zero without a served record");

    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted_oldest |->
            ring_count == ($clog2(RING_DEPTH + 1))'(RING_DEPTH)
            && placed_store == trg_pkg::PLACED_RING)
        else $error("eviction without a full ring");

    a_counts_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stack_count <= ($clog2(STACK_DEPTH + 1))'(STACK_DEPTH)
        && fifo_count <= ($clog2(FIFO_DEPTH + 1))'(FIFO_DEPTH)
        && ring_count <= ($clog2(RING_DEPTH + 1))'(RING_DEPTH))
        else $error("store count beyond depth");

endmodule

bind triage_stack_fifo_ring_engine_top trg_checker #(
    .STACK_DEPTH (STACK_DEPTH),
    .FIFO_DEPTH  (FIFO_DEPTH),
    .RING_DEPTH  (RING_DEPTH)
) u_trg_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .status          (status),
    .served_valid    (served_valid),
    .served_id       (served_id),
    .served_age      (served_age),
    .served_severity (served_severity),
    .placed_store    (placed_store),
    .evicted_oldest  (evicted_oldest),
    .stack_count     (stack_count),
    .fifo_count      (fifo_count),
    .ring_count      (ring_count)
);

`default_nettype wire
